// File: design/pfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  // Field widths of the beats
  localparam int OP_BITS    = 2;
  localparam int ENTRY_BITS = 4;
  localparam int SIZE_BITS  = 16;
  localparam int SUM_BITS   = 20;
  localparam int COUNT_BITS = 5;

  localparam int MAX_PARTITIONS = 16;

  // APB register map
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic [0:0] REG_POLICY = 1'b0;
  localparam logic [0:0] REG_COUNT  = 1'b1;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_PLACE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  typedef struct packed {
    logic [OP_BITS-1:0]    operation;
    logic [ENTRY_BITS-1:0] entry_index;
    logic [SIZE_BITS-1:0]  size;
  } in_beat_t;

  typedef struct packed {
    logic                  placed;
    logic [ENTRY_BITS-1:0] placed_index;
    logic [SIZE_BITS-1:0]  waste;
    logic [SUM_BITS-1:0]   total_waste;
  } out_beat_t;

endpackage

`default_nettype wire

// File: design/partition_fit_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Fixed-partition allocator. Input beats on in_valid/in_ready/in_data carry one
// of: load a partition size (frees that entry), place a job, clear all
// allocations. Every input beat yields exactly one result beat on
// out_valid/out_ready/out_data: placed flag, chosen index, waste and the
// saturating running waste total.
// policy and partition_count are written over the APB port (byte addresses 0
// and 4); the user must write them only while the block is idle, as the
// block itself does not enforce it. Load, clear and unused codes go from idle
// to a finish state that loads the output register. A place walks the table
// one entry per cycle through a single read port of the size memory and one
// compare unit, over min(partition_count, MAX_PARTITIONS) entries, then
// commits and finishes; first and next fit stop early at the first fitting
// entry. One item is in flight at a time; in_ready is high only while idle
// and returns with the result.
// Results sit in an output register, so a new item is accepted while a result
// waits; when the receiver stalls, the next result holds until it drains.
// Reset (synchronous, active high) clears occupied marks, rover, waste total
// and restores policy first fit and partition_count 16. Partition sizes are
// undefined until loaded; no clearing pass is needed.
module partition_fit_allocator_top #(
  parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire pfa_pkg::in_beat_t             in_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      pfa_pkg::out_beat_t            out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pfa_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [pfa_pkg::DATA_BITS-1:0] pwdata,
  output      logic [pfa_pkg::DATA_BITS-1:0] prdata,
  output      logic                          pready
);

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
  localparam int SZ_W  = pfa_pkg::SIZE_BITS;
  localparam int SUM_W = pfa_pkg::SUM_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_FINISH
  } state_t;

  state_t                            state;
  pfa_pkg::policy_t                  policy;
  logic [pfa_pkg::COUNT_BITS-1:0]    pcount;
  logic [MAX_PARTITIONS-1:0]         occupied;
  logic [IDX_W-1:0]                  rover;
  logic [SUM_W-1:0]                  waste_sum;
  logic [SZ_W-1:0]                   job;
  logic [CNT_W-1:0]                  n_reg;
  logic [IDX_W-1:0]                  pos;
  logic [CNT_W-1:0]                  issue_cnt;
  logic                              chk_vld;
  logic [IDX_W-1:0]                  chk_idx;
  logic                              chk_occ;
  logic                              have;
  logic [IDX_W-1:0]                  pick;
  logic [SZ_W-1:0]                   best_size;
  pfa_pkg::out_beat_t                res;

  logic [SZ_W-1:0]                   size_mem [MAX_PARTITIONS];
  logic [SZ_W-1:0]                   rd_data;

  logic                              in_fire;
  logic                              cfg_write;
  logic                              load_ok;
  logic [CNT_W-1:0]                  n_active;
  logic [IDX_W-1:0]                  start_pos;
  logic [CNT_W-1:0]                  pos_inc;
  logic [IDX_W-1:0]                  pos_next;
  logic                              issuing;
  logic                              fit;
  logic [SZ_W-1:0]                   waste_calc;
  logic [SUM_W:0]                    sum_ext;
  logic [SUM_W-1:0]                  sum_sat;

  assign pready    = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign load_ok   = (32'(in_data.entry_index) < MAX_PARTITIONS);

  always_comb begin
    prdata = '0;
    unique case (paddr[2:2])
      pfa_pkg::REG_POLICY: prdata = pfa_pkg::DATA_BITS'(policy);
      pfa_pkg::REG_COUNT:  prdata = pfa_pkg::DATA_BITS'(pcount);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (32'(pcount) > MAX_PARTITIONS) begin
      n_active = CNT_W'(MAX_PARTITIONS);
    end else begin
      n_active = CNT_W'(pcount);
    end
    if (policy == pfa_pkg::POL_NEXT && CNT_W'(rover) < n_active) begin
      start_pos = rover;
    end else begin
      start_pos = '0;
    end
    pos_inc  = CNT_W'(pos) + CNT_W'(1);
    pos_next = (pos_inc < n_reg) ? IDX_W'(pos_inc) : '0;
    issuing  = (issue_cnt < n_reg);
    fit      = chk_vld && !chk_occ && (job <= rd_data);
    waste_calc = best_size - job;
    sum_ext  = {1'b0, waste_sum} + (SUM_W + 1)'(waste_calc);
    sum_sat  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  end

  // Size table: one write port, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (in_fire && in_data.operation == pfa_pkg::OP_LOAD && load_ok) begin
      size_mem[IDX_W'(in_data.entry_index)] <= in_data.size;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && issuing) begin
      rd_data <= size_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      policy    <= pfa_pkg::POL_FIRST;
      pcount    <= pfa_pkg::COUNT_RESET;
      occupied  <= '0;
      rover     <= '0;
      waste_sum <= '0;
      out_valid <= 1'b0;
      chk_vld   <= 1'b0;
      have      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2:2])
          pfa_pkg::REG_POLICY: policy <= pfa_pkg::policy_t'(pwdata[1:0]);
          pfa_pkg::REG_COUNT:  pcount <= pwdata[pfa_pkg::COUNT_BITS-1:0];
          default: ;
        endcase
      end

      // in S_FINISH the output register is reloaded below instead
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res.placed       <= 1'b0;
            res.placed_index <= '0;
            res.waste        <= '0;
            res.total_waste  <= (in_data.operation == pfa_pkg::OP_CLEAR) ? '0 : waste_sum;
            case (in_data.operation)
              pfa_pkg::OP_LOAD: begin
                if (load_ok) begin
                  occupied[IDX_W'(in_data.entry_index)] <= 1'b0;
                end
                state <= S_FINISH;
              end
              pfa_pkg::OP_PLACE: begin
                job       <= in_data.size;
                n_reg     <= n_active;
                pos       <= start_pos;
                issue_cnt <= '0;
                chk_vld   <= 1'b0;
                have      <= 1'b0;
                state     <= S_SCAN;
              end
              pfa_pkg::OP_CLEAR: begin
                occupied  <= '0;
                waste_sum <= '0;
                rover     <= '0;
                state     <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end

        S_SCAN: begin
          // issue one entry per cycle; the compare sees it in the next cycle
          if (issuing) begin
            pos       <= pos_next;
            issue_cnt <= issue_cnt + CNT_W'(1);
            chk_idx   <= pos;
            chk_occ   <= occupied[pos];
          end
          chk_vld <= issuing;

          if (fit) begin
            if (!have) begin
              have      <= 1'b1;
              pick      <= chk_idx;
              best_size <= rd_data;
            end else if ((policy == pfa_pkg::POL_BEST && rd_data < best_size) ||
                         (policy == pfa_pkg::POL_WORST && rd_data > best_size)) begin
              pick      <= chk_idx;
              best_size <= rd_data;
            end
          end

          if ((fit && !have &&
               (policy == pfa_pkg::POL_FIRST || policy == pfa_pkg::POL_NEXT)) ||
              (!issuing && !chk_vld)) begin
            state <= S_COMMIT;
          end
        end

        S_COMMIT: begin
          if (have) begin
            occupied[pick]   <= 1'b1;
            waste_sum        <= sum_sat;
            res.placed       <= 1'b1;
            res.placed_index <= pfa_pkg::ENTRY_BITS'(pick);
            res.waste        <= waste_calc;
            res.total_waste  <= sum_sat;
            if (policy == pfa_pkg::POL_NEXT) begin
              rover <= pick;
            end
          end
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("accepted a beat but stayed ready");

  a_unplaced_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.placed) |-> (out_data.waste == '0 && out_data.placed_index == '0))
    else $error("unplaced result carries index or waste");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_cnt <= n_reg))
    else $error("scan ran past the active partition count");

  a_commit_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && have) |=> occupied[$past(pick)])
    else $error("placed entry not marked occupied");

endmodule

`default_nettype wire
